@@ sv/nmru_pkg.sv @@
// ----------------------------------------------------------------------------
// NMRU replacement package
// Shared sizes, operation codes and the per-set state entry.
// ----------------------------------------------------------------------------
package nmru_pkg;

	localparam int NUM_SETS = 64;
	localparam int NUM_WAYS = 8;

	// Fixed field widths of the request and response
	localparam int OP_W  = 2;
	localparam int SET_W = 6;
	localparam int WAY_W = 3;

	// Memory index width follows the set count
	localparam int IDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

	typedef enum logic [OP_W-1:0] {
		OP_TOUCH  = 2'd0,
		OP_FILL   = 2'd1,
		OP_INVAL  = 2'd2,
		OP_VICTIM = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [NUM_WAYS-1:0] valid;
		logic [WAY_W-1:0]    mru;
	} entry_t;

endpackage

@@ sv/nmru_req_if.sv @@
// ----------------------------------------------------------------------------
// NMRU request channel
// Valid/ready channel carrying one policy operation.
// ----------------------------------------------------------------------------
interface nmru_req_if;

	logic                          valid;
	logic                          ready;
	nmru_pkg::opcode_t             opcode;
	logic [nmru_pkg::SET_W-1:0]    set_index;
	logic [nmru_pkg::WAY_W-1:0]    way;
	logic [nmru_pkg::WAY_W-1:0]    random_pick;

	modport source (output valid, opcode, set_index, way, random_pick, input ready);
	modport sink (input valid, opcode, set_index, way, random_pick, output ready);

endinterface

@@ sv/nmru_rsp_if.sv @@
// ----------------------------------------------------------------------------
// NMRU response channel
// Valid/ready channel carrying the victim answer of one request.
// ----------------------------------------------------------------------------
interface nmru_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [nmru_pkg::WAY_W-1:0]    victim_way;
	logic                          victim_was_invalid;

	modport source (output valid, victim_way, victim_was_invalid, input ready);
	modport sink (input valid, victim_way, victim_was_invalid, output ready);

endinterface

@@ sv/nmru_replacement_policy.sv @@
// ----------------------------------------------------------------------------
// NMRU replacement policy
// Not-most-recently-used victim selection for a set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one request per handshake: opcode, set_index, way and
//   random_pick. Touch and fill mark the way valid and MRU, invalidate
//   clears its valid bit, victim returns the lowest invalid way or a
//   random non-MRU way.
//   rsp (source): exactly one response per request, in request order;
//   victim_way and victim_was_invalid are zero for all but victim requests.
// Timing:
//   The set entry is read from a synchronous memory at the accept edge;
//   once the output register is free, the answer is computed, the entry
//   is written back and the output register is loaded. No new request is
//   accepted until the current one has finished.
// Reset:
//   arst_n clears a per-set flag register, so every set reads as all ways
//   invalid with MRU zero right after reset; no clearing pass is needed.
// Stall:
//   A stalled response is held; a request already read waits for the
//   output register, and req.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module nmru_replacement_policy (
	input  logic        clk,
	input  logic        arst_n,
	nmru_req_if.sink    req,
	nmru_rsp_if.source  rsp
);

	localparam logic [nmru_pkg::WAY_W:0]   WAYS_N   = (nmru_pkg::WAY_W+1)'(nmru_pkg::NUM_WAYS);
	localparam logic [nmru_pkg::WAY_W-1:0] PICK_MOD = nmru_pkg::WAY_W'(nmru_pkg::NUM_WAYS - 1);
	localparam logic [nmru_pkg::SET_W:0]   SETS_N   = (nmru_pkg::SET_W+1)'(nmru_pkg::NUM_SETS);

	nmru_pkg::entry_t mem [nmru_pkg::NUM_SETS];

	logic [nmru_pkg::NUM_SETS-1:0] written_q;
	logic                          busy_q;
	logic                          out_valid_q;
	logic [nmru_pkg::WAY_W-1:0]    victim_q;
	logic                          inv_q;

	nmru_pkg::entry_t              rd_s1;
	nmru_pkg::opcode_t             op_s1;
	logic [nmru_pkg::IDX_W-1:0]    idx_s1;
	logic                          set_ok_s1;
	logic [nmru_pkg::WAY_W-1:0]    way_s1;
	logic [nmru_pkg::WAY_W-1:0]    pick_s1;
	logic                          hit_s1;

	logic                          accept;
	logic                          finish;
	logic [nmru_pkg::IDX_W-1:0]    rd_idx;
	nmru_pkg::entry_t              cur;
	nmru_pkg::entry_t              nxt;
	logic                          wr_en;
	logic                          way_ok;
	logic                          found;
	logic [nmru_pkg::WAY_W-1:0]    first_inv;
	logic [nmru_pkg::WAY_W-1:0]    pick_red;
	logic [nmru_pkg::WAY_W-1:0]    victim_d;
	logic                          inv_d;

	assign req.ready = !busy_q;
	assign accept    = req.valid && req.ready;
	assign finish    = busy_q && (!out_valid_q || rsp.ready);
	assign rd_idx    = req.set_index[nmru_pkg::IDX_W-1:0];

	assign rsp.valid              = out_valid_q;
	assign rsp.victim_way         = victim_q;
	assign rsp.victim_was_invalid = inv_q;

	// Sets never written since reset read as all invalid, MRU zero
	assign cur    = hit_s1 ? rd_s1 : '0;
	assign way_ok = {1'b0, way_s1} < WAYS_N;

	always_comb begin
		found     = 1'b0;
		first_inv = '0;
		for (int i = nmru_pkg::NUM_WAYS - 1; i >= 0; i--) begin
			if (!cur.valid[i]) begin
				found     = 1'b1;
				first_inv = nmru_pkg::WAY_W'(i);
			end
		end
	end

	// Pick is below twice the modulus: one compare and subtract
	assign pick_red = (pick_s1 >= PICK_MOD) ? pick_s1 - PICK_MOD : pick_s1;

	always_comb begin
		nxt      = cur;
		wr_en    = 1'b0;
		victim_d = '0;
		inv_d    = 1'b0;
		if (set_ok_s1) begin
			case (op_s1)
				nmru_pkg::OP_TOUCH, nmru_pkg::OP_FILL: begin
					if (way_ok) begin
						nxt.valid[way_s1] = 1'b1;
						nxt.mru           = way_s1;
						wr_en             = 1'b1;
					end
				end
				nmru_pkg::OP_INVAL: begin
					if (way_ok) begin
						nxt.valid[way_s1] = 1'b0;
						wr_en             = 1'b1;
					end
				end
				nmru_pkg::OP_VICTIM: begin
					if (found) begin
						victim_d = first_inv;
						inv_d    = 1'b1;
					end else begin
						victim_d = (pick_red < cur.mru) ? pick_red : pick_red + 1'b1;
					end
				end
				default: begin
					victim_d = '0;
				end
			endcase
		end
	end

	// Set memory: read at accept, write back when a modifying request finishes
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[rd_idx];
		end
		if (finish && wr_en) begin
			mem[idx_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= req.opcode;
			idx_s1    <= rd_idx;
			set_ok_s1 <= {1'b0, req.set_index} < SETS_N;
			way_s1    <= req.way;
			pick_s1   <= req.random_pick;
		end
		if (finish) begin
			victim_q <= victim_d;
			inv_q    <= inv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q   <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hit_s1      <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				hit_s1 <= written_q[rd_idx];
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish && wr_en) begin
				written_q[idx_s1] <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
